[design/oont_pkg.sv]
package oont_pkg;

    // Fixed field widths of the request and result items.
    localparam int SEQ_W    = 64;
    localparam int STATUS_W = 2;

    // Default size of the tracking window, in sequence numbers.
    localparam int WINDOW_DEF = 64;

    // Expected base after reset.
    localparam logic [SEQ_W-1:0] BASE_RESET = 64'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_STALE     = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_BEYOND    = 2'd3
    } status_t;

    // Carry between neighboring cells. The run member follows the run of
    // seen marks that starts at the head cell and goes upward; the wrap
    // member continues that run from cell zero up to just below the head.
    typedef struct packed {
        logic run;
        logic wrap;
    } link_t;

    // Per-cell control that the chain hands to each cell.
    typedef struct packed {
        logic upd;
        logic hit;
        logic is_head;
        logic below_head;
    } cell_ctl_t;

endpackage

[design/oont_cell.sv]
module oont_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  oont_pkg::cell_ctl_t ctl,
    input  oont_pkg::link_t    link_in,
    output oont_pkg::link_t    link_out,
    output logic               seen,
    output logic               run_end
);
    import oont_pkg::*;

    logic seen_reg;
    logic seen_next;
    logic marked;
    logic carry_lin;
    logic carry;
    logic in_run;

    // The mark as it stands once the current request has set its bit.
    assign marked    = seen_reg | ctl.hit;
    assign carry_lin = ctl.is_head | link_in.run;
    assign carry     = carry_lin | (link_in.wrap & ctl.below_head);
    assign in_run    = marked & carry;

    assign link_out.run  = marked & carry_lin;
    assign link_out.wrap = marked & link_in.wrap & ctl.below_head;

    // This cell is the first unmarked one after the consumed run.
    assign run_end = carry & ~marked;
    assign seen    = seen_reg;

    always_comb
    begin
        seen_next = seen_reg;
        if (ctl.upd)
        begin
            seen_next = marked & ~in_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

[design/oont_chain.sv]
module oont_chain #(
    parameter int WINDOW = oont_pkg::WINDOW_DEF,
    parameter int IW     = $clog2(WINDOW),
    parameter int CW     = $clog2(WINDOW + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          upd,
    input  logic [IW-1:0] pos,
    input  logic [IW-1:0] head,
    output logic          seen_at_pos,
    output logic [CW-1:0] adv_cnt,
    output logic [IW-1:0] new_head
);
    import oont_pkg::*;

    cell_ctl_t        ctl      [WINDOW];
    link_t            link_in  [WINDOW];
    link_t            link_out [WINDOW];
    logic [WINDOW-1:0] seen_vec;
    logic [WINDOW-1:0] end_vec;
    logic [IW-1:0]    end_idx;
    logic             any_end;

    // Cell zero continues the run that leaves the top cell, which closes
    // the ring without a combinational loop.
    assign link_in[0] = '{run: 1'b0, wrap: link_out[WINDOW-1].run};

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        assign ctl[i].upd        = upd;
        assign ctl[i].hit        = upd & (pos == IW'(i));
        assign ctl[i].is_head    = (head == IW'(i));
        assign ctl[i].below_head = (IW'(i) < head);

        if (i > 0)
        begin : g_link
            assign link_in[i] = link_out[i-1];
        end

        oont_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[i]),
            .link_in  (link_in[i]),
            .link_out (link_out[i]),
            .seen     (seen_vec[i]),
            .run_end  (end_vec[i])
        );
    end

    assign seen_at_pos = seen_vec[pos];
    assign any_end     = |end_vec;

    // At most one cell ends the run, so an OR of masked indexes encodes it.
    always_comb
    begin
        end_idx = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (end_vec[i])
            begin
                end_idx = end_idx | IW'(i);
            end
        end
    end

    // With every mark set the whole window is consumed and the head
    // comes back around to where it started.
    always_comb
    begin
        new_head = head;
        adv_cnt  = CW'(WINDOW);
        if (any_end)
        begin
            new_head = end_idx;
            if (end_idx >= head)
            begin
                adv_cnt = CW'(end_idx) - CW'(head);
            end
            else
            begin
                adv_cnt = CW'(end_idx) + CW'(WINDOW) - CW'(head);
            end
        end
    end

endmodule

[design/out_of_order_nonce_tracker_unit.sv]
// A request's result is written into the output register when the request is taken.
// Throughput: one request per cycle while the output register is not held by a stall; the
// window check, mark update and base advance all resolve in a single pass through the
// chain of per-number cells. Reset (asynchronous, active low) sets the expected base to 1,
// the head to cell zero, and clears every seen mark and the output register's valid flag.
module out_of_order_nonce_tracker_unit #(
    parameter int WINDOW = oont_pkg::WINDOW_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           event_valid,
    output logic                           event_stall,
    input  logic [oont_pkg::SEQ_W-1:0]     event_seq,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [oont_pkg::STATUS_W-1:0]  status,
    output logic [oont_pkg::SEQ_W-1:0]     next_expected
);
    import oont_pkg::*;

    localparam int IW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [IW:0] WIN_SUM = (IW + 1)'(WINDOW);

    // The seen marks live in a ring of cells. The head register names the
    // cell that stands for the expected base, so advancing the base only
    // moves the head and clears the consumed cells; nothing shifts.
    logic [SEQ_W-1:0] base_reg;
    logic [SEQ_W-1:0] base_next;
    logic [IW-1:0]    head_reg;
    logic [IW-1:0]    head_next;

    // Output register. It holds one finished result, and a new request is
    // taken whenever the slot is empty or is being emptied this cycle.
    logic             result_valid_reg;
    logic             result_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [SEQ_W-1:0] next_expected_reg;

    logic             take;
    logic             stale;
    logic             beyond;
    logic             dup;
    logic [SEQ_W-1:0] seq_gap;
    logic [IW:0]      pos_sum;
    logic [IW-1:0]    pos;
    logic             upd;
    status_t          st;
    logic             seen_at_pos;
    logic [CW-1:0]    adv_cnt;
    logic [IW-1:0]    new_head;

    assign event_stall = result_valid_reg & result_stall;
    assign take        = event_valid & ~event_stall;

    // Classify the request against the current window. The distance is
    // only meaningful when the number is not stale, so it never wraps.
    assign stale   = (event_seq < base_reg);
    assign seq_gap = event_seq - base_reg;
    assign beyond  = ~stale & (seq_gap >= SEQ_W'(WINDOW));

    // Ring position of the number: head plus distance, folded once.
    assign pos_sum = {1'b0, head_reg} + {1'b0, seq_gap[IW-1:0]};
    assign pos     = (pos_sum >= WIN_SUM) ? IW'(pos_sum - WIN_SUM) : pos_sum[IW-1:0];

    assign dup = ~stale & ~beyond & seen_at_pos;

    always_comb
    begin
        if (stale)
        begin
            st = ST_STALE;
        end
        else if (beyond)
        begin
            st = ST_BEYOND;
        end
        else if (dup)
        begin
            st = ST_DUPLICATE;
        end
        else
        begin
            st = ST_ACCEPTED;
        end
    end

    // Only an accepted request touches the state; rejections leave the
    // base, the head and the marks exactly as they were.
    assign upd = take & (st == ST_ACCEPTED);

    oont_chain #(
        .WINDOW (WINDOW),
        .IW     (IW),
        .CW     (CW)
    ) u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (upd),
        .pos         (pos),
        .head        (head_reg),
        .seen_at_pos (seen_at_pos),
        .adv_cnt     (adv_cnt),
        .new_head    (new_head)
    );

    // The base advances by the length of the consumed run and wraps
    // modulo 2^64 like a plain counter.
    assign base_next = upd ? (base_reg + SEQ_W'(adv_cnt)) : base_reg;
    assign head_next = upd ? new_head : head_reg;

    assign result_valid_next = take | (result_valid_reg & result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg         <= BASE_RESET;
            head_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg         <= base_next;
            head_reg         <= head_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg        <= st;
            next_expected_reg <= base_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign next_expected = next_expected_reg;

    // The head always names a cell that exists.
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < IW'(WINDOW - 1) || head_reg == IW'(WINDOW - 1))
        else $error("head pointer outside the window");

    // A rejected request leaves the expected base unchanged.
    a_reject_keeps_base: assert property (@(posedge clk) disable iff (!rst_n)
        take && st != ST_ACCEPTED |=> base_reg == $past(base_reg))
        else $error("rejected request moved the base");

    // The reported base of a taken request matches the updated base register.
    a_result_base: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> next_expected == base_reg)
        else $error("reported base differs from the tracker base");

endmodule

[tb/sv/testbench.sv]
// Scoreboard for the sliding-window sequence tracker. It keeps its own copy of
// the expected base and of the seen marks. It works out the verdict for every
// accepted request and checks the results against those verdicts in order.
class nonce_scoreboard;

    typedef struct {
        oont_pkg::status_t             status;
        logic [oont_pkg::SEQ_W-1:0]    next_base;
    } verdict_t;

    logic [oont_pkg::SEQ_W-1:0]        win_base;
    logic [oont_pkg::WINDOW_DEF-1:0]   seen_bits;
    verdict_t                          pending_verdicts[$];
    int                                mismatches;
    int                                checked;
    int                                tally[4];

    function new();
        win_base   = oont_pkg::BASE_RESET;
        seen_bits  = '0;
        mismatches = 0;
        checked    = 0;
        foreach (tally[i]) tally[i] = 0;
    endfunction

    // Applies one accepted request to the tracked state and queues its verdict.
    function void note_request(input logic [oont_pkg::SEQ_W-1:0] seq);
        verdict_t                    v;
        logic [oont_pkg::SEQ_W-1:0]  seq_gap;
        if (seq < win_base)
        begin
            v.status = oont_pkg::ST_STALE;
        end
        else
        begin
            seq_gap = seq - win_base;
            if (seq_gap >= oont_pkg::WINDOW_DEF)
            begin
                v.status = oont_pkg::ST_BEYOND;
            end
            else if (seen_bits[seq_gap])
            begin
                v.status = oont_pkg::ST_DUPLICATE;
            end
            else
            begin
                v.status = oont_pkg::ST_ACCEPTED;
                seen_bits[seq_gap] = 1'b1;
                // The shift brings in zeros, so this run always ends.
                while (seen_bits[0])
                begin
                    seen_bits = seen_bits >> 1;
                    win_base  = win_base + 1'b1;
                end
            end
        end
        v.next_base = win_base;
        pending_verdicts.push_back(v);
    endfunction

    // Compares one accepted result with the oldest verdict still waiting.
    function void check_result(input logic [oont_pkg::STATUS_W-1:0] st,
                               input logic [oont_pkg::SEQ_W-1:0] nxt);
        verdict_t v;
        checked++;
        if (pending_verdicts.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result with no request waiting: status %0d base %0h",
                         st, nxt);
            return;
        end
        v = pending_verdicts.pop_front();
        if (st !== v.status || nxt !== v.next_base)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d: status exp %0d got %0d, base exp %0h got %0h",
                         checked, v.status, st, v.next_base, nxt);
        end
        else
        begin
            tally[v.status]++;
        end
    endfunction

endclass

module testbench;

    import oont_pkg::*;

    localparam int WIN          = WINDOW_DEF;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_ITEMS   = 1080;
    localparam int LIMIT_CYCLES = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              event_valid = 1'b0;
    logic              event_stall;
    logic [SEQ_W-1:0]  event_seq = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]  next_expected;

    // Chance, in percent, that the sender or the receiver idles on a cycle.
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit                hold_request = 1'b0;
    int                cycle_count = 0;
    int                requests_sent = 0;

    nonce_scoreboard   sb = new();

    out_of_order_nonce_tracker_unit #(
        .WINDOW (WIN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .event_valid   (event_valid),
        .event_stall   (event_stall),
        .event_seq     (event_seq),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .next_expected (next_expected)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog. A correct run finishes far below this limit, even with the long
    // hold-off and the receiver stalling more than half of the time.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Both handshakes are observed at the same edge, in a fixed order. The request
    // is noted first, although its result can only show up in the following cycle anyway.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (event_valid && !event_stall)
                sb.note_request(event_seq);
            if (result_valid && !result_stall)
                sb.check_result(status, next_expected);
        end
    end

    // Receiver. Usually it stalls at random. When a hold-off is asked for, it
    // stalls for a long stretch, so that the block fills up and pushes back on
    // the sender, which keeps offering requests the whole time.
    always
    begin
        @(posedge clk);
        if (hold_request)
        begin
            hold_request = 1'b0;
            result_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
        else
        begin
            result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Offers one request, with random idle cycles in front of it, and returns at
    // the edge where the block takes it. The payload holds steady while stalled.
    task automatic send_request(input logic [SEQ_W-1:0] seq);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            event_valid <= 1'b0;
            @(posedge clk);
        end
        event_valid <= 1'b1;
        event_seq   <= seq;
        @(posedge clk);
        while (event_stall) @(posedge clk);
        requests_sent++;
    endtask

    // Picks a sequence number around the tracked base. Most numbers land in the
    // window, many right at the base so that the base keeps moving. The rest are
    // stale numbers, repeats of numbers already marked, numbers just past the
    // window edge, and plain 64-bit noise.
    function automatic logic [SEQ_W-1:0] pick_seq();
        logic [SEQ_W-1:0] b;
        int               r;
        int               pos;
        b = sb.win_base;
        r = $urandom_range(99);
        if (r < 40)
            return b + $urandom_range(7);
        if (r < 65)
            return b + $urandom_range(WIN - 1);
        if (r < 73)
            return b + WIN - 1 + $urandom_range(3);
        if (r < 81)
            return b - 1 - $urandom_range(5);
        if (r < 92)
        begin
            // Repeat a number that is already marked, when there is one.
            for (int k = 0; k < 8; k++)
            begin
                pos = $urandom_range(WIN - 1);
                if (sb.seen_bits[pos])
                    return b + pos;
            end
            return b - 1;
        end
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        logic [SEQ_W-1:0] directed[$];

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, written against the reset base of one. It covers the
        // field extremes, the stale and duplicate cases, both edges of the
        // window, out-of-order arrival and a base that jumps past a marked run.
        directed = '{
            64'd0,                          // stale, below the reset base
            64'hFFFF_FFFF_FFFF_FFFF,        // far beyond the window
            64'd1,                          // accepted, base moves to 2
            64'd1,                          // now stale
            64'd2 + WIN - 1,                // last number inside the window
            64'd2 + WIN,                    // first number past the window
            64'd2 + WIN - 1,                // duplicate at the window top
            64'd3,                          // out of order, base stays at 2
            64'd3,                          // duplicate
            64'd2,                          // base runs past 2 and 3 to 4
            64'd6,
            64'd7,
            64'd5,
            64'd4,                          // base runs past 4 through 7 to 8
            64'd7,                          // stale after the run
            64'h8000_0000_0000_0000,
            64'h5555_5555_5555_5555,
            64'hAAAA_AAAA_AAAA_AAAA,
            64'd8,                          // accepted, base moves to 9
            64'd9 + WIN,                    // one past the window again
            64'd9 + WIN - 2
        };

        tx_idle_pct = 14;
        rx_idle_pct = 54;
        foreach (directed[i])
            send_request(directed[i]);

        // The long hold-off falls in the first random phase.
        hold_request = 1'b1;

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == RAND_ITEMS / 3)
            begin
                tx_idle_pct = 54;
                rx_idle_pct = 14;
            end
            else if (i == 2 * RAND_ITEMS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_request(pick_seq());
        end
        event_valid <= 1'b0;

        // Drain the remaining results, then give the block a few more cycles to
        // show any result that should not be there.
        while (sb.pending_verdicts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d requests and checked %0d results, final base %0h.",
                 requests_sent, sb.checked, sb.win_base);
        $display("Matched: %0d accepted, %0d stale, %0d duplicate, %0d beyond window.",
                 sb.tally[ST_ACCEPTED], sb.tally[ST_STALE],
                 sb.tally[ST_DUPLICATE], sb.tally[ST_BEYOND]);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches in total.", sb.mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[out_of_order_nonce_tracker_unit.f]
design/oont_pkg.sv
design/oont_cell.sv
design/oont_chain.sv
design/out_of_order_nonce_tracker_unit.sv
tb/sv/testbench.sv
